>>> rtl/tjeq_pkg.sv
`timescale 1ns / 1ps

package tjeq_pkg;

    // Sizing of the calibration path and the joystick samples
    localparam int CALIB_SAMPLES = 16;
    localparam int ADC_BITS      = 12;
    localparam int CNT_W         = $clog2(CALIB_SAMPLES);
    localparam int SUM_W         = ADC_BITS + CNT_W;

    // Fixed widths of the item and register fields
    localparam int TIME_W  = 32;
    localparam int PAD_W   = 16;
    localparam int NUM_PADS = 4;
    localparam int DZ_W    = 12;
    localparam int RPT_W   = 16;
    localparam int EV_W    = 4;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 16;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_DEADZONE        = 3'd0;
    localparam logic [CIDX_W-1:0] REG_REPEAT_INTERVAL = 3'd1;
    localparam logic [CIDX_W-1:0] REG_PRESS_LIMIT     = 3'd2;
    localparam logic [CIDX_W-1:0] REG_TOUCH_ENABLE    = 3'd3;
    localparam logic [CIDX_W-1:0] REG_JOY_ENABLE      = 3'd4;

    // Register reset values
    localparam logic [DZ_W-1:0]    DEADZONE_RST  = 12'd1050;
    localparam logic [RPT_W-1:0]   REPEAT_RST    = 16'd180;
    localparam logic [PAD_W-1:0]   THRESHOLD_RST = 16'd35;

    typedef enum logic {
        OP_CALIB  = 1'b0,
        OP_UPDATE = 1'b1
    } op_t;

    typedef enum logic [EV_W-1:0] {
        EV_NONE   = 4'd0,
        EV_SELECT = 4'd1,
        EV_BACK   = 4'd2,
        EV_START  = 4'd3,
        EV_MENU   = 4'd4,
        EV_RIGHT  = 4'd5,
        EV_LEFT   = 4'd6,
        EV_DOWN   = 4'd7,
        EV_UP     = 4'd8
    } event_t;

    typedef struct packed {
        logic [DZ_W-1:0]  deadzone;
        logic [RPT_W-1:0] repeat_interval;
        logic [PAD_W-1:0] press_limit;
        logic             touch_enable;
        logic             joystick_enable;
    } cfg_t;

    typedef struct packed {
        op_t                 opcode;
        logic [TIME_W-1:0]   now;
        logic [PAD_W-1:0]    pad_zero;
        logic [PAD_W-1:0]    pad_one;
        logic [PAD_W-1:0]    pad_two;
        logic [PAD_W-1:0]    pad_three;
        logic [ADC_BITS-1:0] joy_x;
        logic [ADC_BITS-1:0] joy_y;
    } item_t;

    typedef struct packed {
        event_t event_code;
        logic   calib_done;
    } result_t;

endpackage

>>> rtl/tjeq_cfg.sv
`timescale 1ns / 1ps

module tjeq_cfg
    import tjeq_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  logic [CIDX_W-1:0]  wr_index,
    input  logic [CDATA_W-1:0] wr_data,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                REG_DEADZONE:        cfg_next.deadzone        = wr_data[DZ_W-1:0];
                REG_REPEAT_INTERVAL: cfg_next.repeat_interval = wr_data[RPT_W-1:0];
                REG_PRESS_LIMIT:     cfg_next.press_limit     = wr_data[PAD_W-1:0];
                REG_TOUCH_ENABLE:    cfg_next.touch_enable    = wr_data[0];
                REG_JOY_ENABLE:      cfg_next.joystick_enable = wr_data[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.deadzone        <= DEADZONE_RST;
            cfg_reg.repeat_interval <= REPEAT_RST;
            cfg_reg.press_limit     <= THRESHOLD_RST;
            cfg_reg.touch_enable    <= 1'b1;
            cfg_reg.joystick_enable <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/tjeq_eval.sv
`timescale 1ns / 1ps

module tjeq_eval
    import tjeq_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    localparam int RCP_SHIFT = SUM_W + CNT_W;
    localparam int PROD_W    = 2 * SUM_W + 1;
    localparam logic [SUM_W:0] RECIP = (SUM_W + 1)'(
        ((64'd1 << RCP_SHIFT) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES));
    localparam logic [ADC_BITS-1:0] CENTER_RST = ADC_BITS'(1) << (ADC_BITS - 1);
    localparam int CMP_W = (ADC_BITS > DZ_W) ? ADC_BITS : DZ_W;

    logic [NUM_PADS-1:0] pad_held_reg, pad_held_next;
    logic [TIME_W-1:0]   last_time_reg, last_time_next;
    logic [ADC_BITS-1:0] center_x_reg, center_x_next;
    logic [ADC_BITS-1:0] center_y_reg, center_y_next;
    logic [SUM_W-1:0]    sum_x_reg, sum_x_next;
    logic [SUM_W-1:0]    sum_y_reg, sum_y_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    logic [PAD_W-1:0]    pad_rd [NUM_PADS];
    logic [SUM_W-1:0]    acc_x, acc_y;
    logic [PROD_W-1:0]   prod_x, prod_y;
    logic                last_sample;

    logic [NUM_PADS-1:0] held_scan;
    event_t              touch_ev;
    logic                touch_hit;

    logic signed [ADC_BITS:0] dx, dy;
    logic [ADC_BITS-1:0]      ax, ay;
    logic [CMP_W-1:0]         ax_c, ay_c, dz_c;
    logic [TIME_W-1:0]        elapsed;
    logic                     joy_open;
    event_t                   joy_ev;
    result_t                  res_c;

    assign pad_rd[0] = item.pad_zero;
    assign pad_rd[1] = item.pad_one;
    assign pad_rd[2] = item.pad_two;
    assign pad_rd[3] = item.pad_three;

    // Calibration accumulate; floor(sum / CALIB_SAMPLES) by reciprocal multiply
    assign acc_x       = sum_x_reg + SUM_W'(item.joy_x);
    assign acc_y       = sum_y_reg + SUM_W'(item.joy_y);
    assign prod_x      = PROD_W'(acc_x) * PROD_W'(RECIP);
    assign prod_y      = PROD_W'(acc_y) * PROD_W'(RECIP);
    assign last_sample = (count_reg == CNT_W'(CALIB_SAMPLES - 1));

    // Priority scan: first newly pressed pad wins, released pads before it clear
    always_comb begin
        logic stop;
        logic down;
        held_scan = pad_held_reg;
        touch_ev  = EV_NONE;
        stop      = 1'b0;
        for (int i = 0; i < NUM_PADS; i++) begin
            down = (pad_rd[i] < cfg.press_limit);
            if (!stop) begin
                if (down && !pad_held_reg[i]) begin
                    held_scan[i] = 1'b1;
                    touch_ev     = event_t'(EV_W'(i + 1));
                    stop         = 1'b1;
                end else if (!down) begin
                    held_scan[i] = 1'b0;
                end
            end
        end
    end

    assign touch_hit = cfg.touch_enable && (touch_ev != EV_NONE);

    // Joystick: dominant axis beyond the deadzone, ties go to vertical
    assign dx   = $signed({1'b0, item.joy_x}) - $signed({1'b0, center_x_reg});
    assign dy   = $signed({1'b0, item.joy_y}) - $signed({1'b0, center_y_reg});
    assign ax   = dx[ADC_BITS] ? ADC_BITS'(-dx) : dx[ADC_BITS-1:0];
    assign ay   = dy[ADC_BITS] ? ADC_BITS'(-dy) : dy[ADC_BITS-1:0];
    assign ax_c = CMP_W'(ax);
    assign ay_c = CMP_W'(ay);
    assign dz_c = CMP_W'(cfg.deadzone);

    assign elapsed  = item.now - last_time_reg;
    assign joy_open = cfg.joystick_enable && (elapsed >= TIME_W'(cfg.repeat_interval));

    always_comb begin
        joy_ev = EV_NONE;
        if (ax_c > ay_c && ax_c > dz_c) begin
            joy_ev = dx[ADC_BITS] ? EV_LEFT : EV_RIGHT;
        end else if (ay_c > dz_c) begin
            joy_ev = dy[ADC_BITS] ? EV_UP : EV_DOWN;
        end
    end

    always_comb begin
        pad_held_next  = pad_held_reg;
        last_time_next = last_time_reg;
        center_x_next  = center_x_reg;
        center_y_next  = center_y_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        count_next     = count_reg;
        res_c.event_code = EV_NONE;
        res_c.calib_done = 1'b0;
        if (item.opcode == OP_CALIB) begin
            if (last_sample) begin
                res_c.calib_done = 1'b1;
            end
            if (fire) begin
                if (last_sample) begin
                    center_x_next = prod_x[RCP_SHIFT +: ADC_BITS];
                    center_y_next = prod_y[RCP_SHIFT +: ADC_BITS];
                    sum_x_next    = '0;
                    sum_y_next    = '0;
                    count_next    = '0;
                end else begin
                    sum_x_next = acc_x;
                    sum_y_next = acc_y;
                    count_next = count_reg + CNT_W'(1);
                end
            end
        end else begin
            if (cfg.touch_enable && fire) begin
                pad_held_next = held_scan;
            end
            if (touch_hit) begin
                res_c.event_code = touch_ev;
            end else if (joy_open) begin
                res_c.event_code = joy_ev;
            end
            if (fire && res_c.event_code != EV_NONE) begin
                last_time_next = item.now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_held_reg  <= '0;
            last_time_reg <= '0;
            center_x_reg  <= CENTER_RST;
            center_y_reg  <= CENTER_RST;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            count_reg     <= '0;
        end else begin
            pad_held_reg  <= pad_held_next;
            last_time_reg <= last_time_next;
            center_x_reg  <= center_x_next;
            center_y_reg  <= center_y_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            count_reg     <= count_next;
        end
    end

    assign res = res_c;

`ifndef ASSERT_OFF
    // A completed calibration set restarts the sample count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && res_c.calib_done) |=> (count_reg == '0))
        else $error("calibration count not cleared after completion");

    // A touch event always leaves its pad marked as held
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && touch_hit && item.opcode == OP_UPDATE) |=> (pad_held_reg != '0))
        else $error("touch event without held pad");
`endif

endmodule

>>> rtl/touch_joystick_event_qualifier.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// s_*       in         s_valid / s_ready    opcode, now, pad readings, joy_x, joy_y
// m_*       out        m_valid / m_ready    event_res, calib_done
// cfg_*     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One request per cycle sustained while m_ready stays high; each request passes
// through the input register, then the result register, before it is valid at m_*.
// All event and calibration work is one combinational pass between the two.
// aresetn is synchronous, active low; it clears both valid flags, the pad
// flags, the event time, the sums and count, and sets centers to mid-scale.
// A stalled m_ready holds the result register; the input register still takes
// one more request, then s_ready drops until the result is taken.
// cfg_ready is always high.

module touch_joystick_event_qualifier
    import tjeq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_opcode,
    input  logic [TIME_W-1:0]   s_now,
    input  logic [PAD_W-1:0]    s_pad_zero,
    input  logic [PAD_W-1:0]    s_pad_one,
    input  logic [PAD_W-1:0]    s_pad_two,
    input  logic [PAD_W-1:0]    s_pad_three,
    input  logic [ADC_BITS-1:0] s_joy_x,
    input  logic [ADC_BITS-1:0] s_joy_y,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [EV_W-1:0]     m_event_res,
    output logic                m_calib_done,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [CDATA_W-1:0]  cfg_data
);

    cfg_t    cfg;
    result_t res;

    logic    in_valid_reg, in_valid_next;
    item_t   item_reg, item_next;
    logic    out_valid_reg, out_valid_next;
    result_t res_reg, res_next;

    logic    s_fire;
    logic    advance;

    // Configuration is taken on any cycle
    assign cfg_ready = 1'b1;

    tjeq_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Advance the held request into the result register when that slot frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    tjeq_eval u_eval (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_comb begin
        item_next     = item_reg;
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            item_next.opcode    = op_t'(s_opcode);
            item_next.now       = s_now;
            item_next.pad_zero  = s_pad_zero;
            item_next.pad_one   = s_pad_one;
            item_next.pad_two   = s_pad_two;
            item_next.pad_three = s_pad_three;
            item_next.joy_x     = s_joy_x;
            item_next.joy_y     = s_joy_y;
            in_valid_next       = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        if (advance) begin
            res_next       = res;
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            // drop the result once it is taken
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers hold without reset
    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_event_res  = res_reg.event_code;
    assign m_calib_done = res_reg.calib_done;

`ifndef ASSERT_OFF
    // A calibration result never carries an event
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_calib_done && m_event_res != EV_NONE))
        else $error("calibration result carries an event");

    // Input side stalls only when both stages are full and the output is blocked
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without back-pressure");

    // A request that advances shows up at the output in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("advanced request missing at output");
`endif

endmodule
